[design/asfu_pkg.sv]
// ----------------------------------------------------------------------------
// asfu_pkg
// Shared types, constants and helpers for the ADC SPI frame unpacker.
// ----------------------------------------------------------------------------
package asfu_pkg;

  localparam int CHANNELS     = 6;
  localparam int STATUS_BYTES = 3;
  localparam int POS_W        = 5;
  localparam int CH_W         = 3;
  localparam int SAMPLE_W     = 16;
  localparam int COUNT_W      = 16;

  localparam logic [POS_W-1:0] POS_IDLE    = 5'd31;
  localparam logic [POS_W-1:0] POS_STATUS  = POS_W'(STATUS_BYTES);
  localparam logic [POS_W-1:0] LEN_WIDE    = POS_W'(STATUS_BYTES + CHANNELS * 3);
  localparam logic [POS_W-1:0] LEN_NARROW  = POS_W'(STATUS_BYTES + CHANNELS * 2);
  localparam logic [CH_W-1:0]  CH_LAST     = CH_W'(CHANNELS - 1);

  // Byte roles inside one channel word
  localparam logic [1:0] R_HIGH = 2'd0;
  localparam logic [1:0] R_MID  = 2'd1;
  localparam logic [1:0] R_LOW  = 2'd2;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [CH_W-1:0]     channel;
    logic                last_in_frame;
    logic [COUNT_W-1:0]  frame_count;
  } asfu_result_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic [1:0]      r;
  } asfu_split_t;

  // Split a word-area byte offset into channel and byte-within-word.
  // Compares against each word boundary in parallel.
  function automatic asfu_split_t asfu_split(input logic [POS_W-1:0] k,
                                             input logic             wide);
    asfu_split_t     res;
    logic [POS_W-1:0] base;
    res.ch = '0;
    for (int i = 1; i < CHANNELS; i++) begin
      if (wide) begin
        if (k >= POS_W'(i * 3)) res.ch = CH_W'(i);
      end else begin
        if (k >= POS_W'(i * 2)) res.ch = CH_W'(i);
      end
    end
    base = wide ? (POS_W'(res.ch) + (POS_W'(res.ch) << 1)) : (POS_W'(res.ch) << 1);
    res.r = 2'(k - base);
    return res;
  endfunction

endpackage

[design/asfu_decode.sv]
// ----------------------------------------------------------------------------
// asfu_decode
// Frame position tracking, word assembly and frame counting per byte.
// ----------------------------------------------------------------------------
module asfu_decode import asfu_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         fire,
  input  logic [7:0]   data_byte,
  input  logic         frame_start,
  input  logic         wide,
  output logic         res_valid,
  output asfu_result_t res
);

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [7:0]         high_r, high_nxt;
  logic [7:0]         mid_r, mid_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;

  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   frame_len;
  logic               active;
  logic               in_words;
  asfu_split_t        sp;
  logic               last;
  logic [COUNT_W-1:0] cnt_inc;

  always_comb begin
    pos       = frame_start ? '0 : pos_r;
    frame_len = wide ? LEN_WIDE : LEN_NARROW;
    active    = pos < frame_len;
    in_words  = active && (pos >= POS_STATUS);
    sp        = asfu_split(pos - POS_STATUS, wide);
    last      = sp.ch == CH_LAST;
    cnt_inc   = cnt_r + COUNT_W'(1);
    res_valid = in_words && (wide ? (sp.r == R_LOW) : (sp.r == R_MID));

    res.sample        = {high_r, (wide ? mid_r : data_byte)};
    res.channel       = sp.ch;
    res.last_in_frame = last;
    res.frame_count   = last ? cnt_inc : cnt_r;
  end

  always_comb begin
    pos_nxt  = pos_r;
    high_nxt = high_r;
    mid_nxt  = mid_r;
    cnt_nxt  = cnt_r;
    if (fire) begin
      pos_nxt = pos;
      if (active) pos_nxt = pos + POS_W'(1);
      if (in_words && sp.r == R_HIGH) high_nxt = data_byte;
      if (in_words && wide && sp.r == R_MID) mid_nxt = data_byte;
      if (res_valid && last) cnt_nxt = cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= POS_IDLE;
      high_r <= '0;
      mid_r  <= '0;
      cnt_r  <= '0;
    end else begin
      pos_r  <= pos_nxt;
      high_r <= high_nxt;
      mid_r  <= mid_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LEN_WIDE || pos_r == POS_IDLE)
    else $error("byte position left its range");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(fire && res_valid && last) |=> $stable(cnt_r))
    else $error("frame counter moved without a frame end");
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> sp.ch <= CH_LAST)
    else $error("channel index beyond channel count");
`endif

endmodule

[design/asfu_out_buf.sv]
// ----------------------------------------------------------------------------
// asfu_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module asfu_out_buf import asfu_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  asfu_result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_stall,
  output asfu_result_t out_data
);

  logic         main_valid_r, main_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  asfu_result_t main_r, main_nxt;
  asfu_result_t skid_r, skid_nxt;
  logic         pop;

  always_comb begin
    pop            = main_valid_r && !out_stall;
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = push_data;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

`ifndef ASSERT_OFF
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held while output register empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("result pushed into a full buffer");
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && pop |=> main_valid_r && !skid_valid_r)
    else $error("skid entry not moved to output register");
`endif

endmodule

[design/adc_spi_frame_unpacker.sv]
// ----------------------------------------------------------------------------
// adc_spi_frame_unpacker
// Unpacks multichannel ADC data frames received over SPI into samples.
// ----------------------------------------------------------------------------
//
//   channel | ports                                      | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid, in_stall, in_data_byte,          | byte in
//           | in_frame_start                             |
//   out     | out_valid, out_stall, out_sample,          | sample out
//           | out_channel, out_last_in_frame,            |
//           | out_frame_count                            |
//   cfg     | cfg_wr_en, cfg_wr_data (wide_samples)      | write only
//
// One byte is taken per cycle while in_stall is low; a completed word is
// registered into the output register, or the skid register if out is stalled.
// A skid register behind the output register lets one more result land while
// out is stalled; in_stall rises only when both are occupied.
// Synchronous active-low reset: position goes idle (awaiting a frame start),
// frame counter and held bytes clear, wide_samples returns to 1.
// ----------------------------------------------------------------------------
module adc_spi_frame_unpacker import asfu_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_frame_start,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_sample,
  output logic [CH_W-1:0]            out_channel,
  output logic                       out_last_in_frame,
  output logic [COUNT_W-1:0]         out_frame_count,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_wr_data
);

  logic         wide_r;
  logic         fire;
  logic         res_valid;
  asfu_result_t res;
  asfu_result_t out_data;
  logic         buf_full;

  // Mode register; read on every byte so a mid-frame change takes effect at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b1;
    end else if (cfg_wr_en) begin
      wide_r <= cfg_wr_data;
    end
  end

  // Transfer of one byte on the in side
  assign fire     = in_valid && !in_stall;
  assign in_stall = buf_full;

  asfu_decode u_decode (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .data_byte   (in_data_byte),
    .frame_start (in_frame_start),
    .wide        (wide_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Push only when the byte actually transfers and completes a word
  asfu_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire && res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_sample        = $signed(out_data.sample);
  assign out_channel       = out_data.channel;
  assign out_last_in_frame = out_data.last_in_frame;
  assign out_frame_count   = out_data.frame_count;

`ifndef ASSERT_OFF
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");
  a_last_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_in_frame == (out_channel == CH_LAST)))
    else $error("last-of-frame mark disagrees with channel index");
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("buffer not empty after reset");
`endif

endmodule
